### hw/rtl/permutation_rearrangement_engine_defines.svh
// Assertion macros used by the checker file of the rearrangement engine.
`ifndef PERMUTATION_REARRANGEMENT_ENGINE_DEFINES_SVH
`define PERMUTATION_REARRANGEMENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PRE_ASSERT_IMP(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("rearrangement engine check failed");

// Next-cycle implication, disabled in reset.
`define PRE_ASSERT_NXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("rearrangement engine check failed");

`endif

### hw/rtl/pre_pkg.sv
// Shared types, codes and helpers of the permutation rearrangement engine.
`default_nettype none
package pre_pkg;

  localparam int MAX_LEN_DEF = 256;

  typedef enum logic [3:0] {
    OP_WRITE    = 4'd0,
    OP_READ     = 4'd1,
    OP_REVERSE  = 4'd2,
    OP_TRANS    = 4'd3,
    OP_BREAK    = 4'd4,
    OP_FIND     = 4'd5,
    OP_STRIP    = 4'd6,
    OP_SINGLE   = 4'd7,
    OP_SORTED   = 4'd8
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ILLEGAL  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic [2:0] T_REV        = 3'd0;
  localparam logic [2:0] T_TRANS_REV  = 3'd1;
  localparam logic [2:0] T_TRANS      = 3'd2;
  localparam logic [2:0] T_SREV       = 3'd3;
  localparam logic [2:0] T_TRANS_SREV = 3'd4;

  localparam logic CFG_TYPE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic brk;
    logic gt;
  } cmp_t;

  // negation that saturates the one value with no positive partner
  function automatic logic signed [8:0] neg9(input logic signed [8:0] v);
    if (v == -9'sd256) return 9'sd255;
    return -v;
  endfunction

  function automatic logic [8:0] mag9(input logic signed [8:0] v);
    if (v[8]) return 9'(-v);
    return 9'(v);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pre_cmp.sv
// Shared compare unit: breakpoint test and ordering of two adjacent elements.
`default_nettype none
module pre_cmp (
  input  logic signed [8:0] lhs,
  input  logic signed [8:0] rhs,
  input  logic [2:0]        ptype,
  output pre_pkg::cmp_t     res
);
  import pre_pkg::*;

  logic signed [9:0] diff;

  always_comb begin
    diff = 10'(rhs) - 10'(lhs);
    // reversal and transposition-reversal types accept a step either way, the others only upward
    if (ptype == T_REV || ptype == T_TRANS_REV) begin
      res.brk = (diff != 10'sd1) && (diff != -10'sd1);
    end else begin
      res.brk = (diff != 10'sd1);
    end
    res.gt = lhs > rhs;
  end

endmodule
`default_nettype wire

### hw/rtl/permutation_rearrangement_engine.sv
// Write and rejected items finish straight from idle; read passes S_PA and S_PB; breakpoint adds S_PC.
// Reverse and transposition swap element pairs through S_PA to S_PD; scans (strip, singleton, sorted) stream the range.
// Find looks up the inverse table (S_LK to S_LK3), rebuilding it by a scan first when it is invalid.
// One item at a time: one element-memory read and one write per cycle set the pace.
// Synchronous reset: type 0, length 2, inverse table invalid; stores undefined until written.
`default_nettype none
module permutation_rearrangement_engine #(
  parameter int MAX_LEN = pre_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [3:0]        operation,
  input  logic [7:0]        pos_i,
  input  logic [7:0]        pos_j,
  input  logic [8:0]        pos_k,
  input  logic signed [8:0] elem_value,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data,
  output logic              busy,
  output logic              done,
  output logic signed [8:0] result_value,
  output logic              result_flag,
  output logic [1:0]        status
);
  import pre_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;

  typedef enum logic [3:0] {
    S_IDLE, S_PA, S_PB, S_PC, S_PD, S_TX, S_SCAN, S_LK, S_LK2, S_LK3
  } state_t;

  state_t state;
  logic [2:0] perm_type;
  logic [8:0] perm_length;
  logic [LW-1:0] len;
  logic [LW-1:0] pi, pj, pk;
  logic type_ok, rev_ok, trn_ok, neg_type;
  op_t op_in;

  op_t op_r;
  logic [LW-1:0] a, b, i_r, j_r, k_r;
  logic neg;
  logic signed [8:0] ea, prev, val_r;
  logic [1:0] tx_ph;
  logic [LW-1:0] sc_raddr, sc_start, sc_end, d_idx;
  logic sc_issue, d_valid, b1, inv_valid;

  logic signed [8:0] emem [MAX_LEN];
  logic [AW-1:0] imem [MAX_LEN];
  logic signed [8:0] rdata;
  logic [AW-1:0] irdata;

  logic e_we;
  logic [AW-1:0] e_wa, e_ra;
  logic signed [8:0] e_wd;
  logic i_we;
  logic [AW-1:0] i_wa;
  logic [8:0] rmag;

  logic signed [8:0] cmp_lhs;
  cmp_t cmp_res;

  logic tx_cond;
  logic [LW-1:0] tx_x, tx_y;

  pre_cmp u_cmp (
    .lhs   (cmp_lhs),
    .rhs   (rdata),
    .ptype (perm_type),
    .res   (cmp_res)
  );

  always_comb begin
    logic [LW-1:0] pl;
    pl = LW'(perm_length);
    if (pl > LW'(MAX_LEN)) len = LW'(MAX_LEN);
    else if (pl < LW'(2)) len = LW'(2);
    else len = pl;
    pi = LW'(pos_i);
    pj = LW'(pos_j);
    pk = LW'(pos_k);
    op_in = op_t'(operation);
    type_ok = perm_type <= T_TRANS_SREV;
    rev_ok = type_ok && (perm_type != T_TRANS);
    trn_ok = (perm_type == T_TRANS_REV) || (perm_type == T_TRANS)
             || (perm_type == T_TRANS_SREV);
    neg_type = (perm_type == T_SREV) || (perm_type == T_TRANS_SREV);
    busy = state != S_IDLE;
    cmp_lhs = (state == S_PC) ? ea : prev;
    rmag = mag9(rdata);
  end

  // three plain reversals of a transposition
  always_comb begin
    unique case (tx_ph)
      2'd0: begin
        tx_cond = k_r > i_r;
        tx_x = i_r;
        tx_y = k_r - LW'(1);
      end
      2'd1: begin
        tx_cond = k_r > j_r;
        tx_x = i_r;
        tx_y = i_r + k_r - j_r - LW'(1);
      end
      2'd2: begin
        tx_cond = j_r > i_r;
        tx_x = i_r + k_r - j_r;
        tx_y = k_r - LW'(1);
      end
      default: begin
        tx_cond = 1'b0;
        tx_x = i_r;
        tx_y = i_r;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_PA:    e_ra = a[AW-1:0];
      S_PB:    e_ra = b[AW-1:0];
      S_LK2:   e_ra = irdata;
      S_SCAN:  e_ra = sc_raddr[AW-1:0];
      default: e_ra = a[AW-1:0];
    endcase
    e_we = 1'b0;
    e_wa = a[AW-1:0];
    e_wd = elem_value;
    if (state == S_IDLE && start && op_in == OP_WRITE && pi < len) begin
      e_we = 1'b1;
      e_wa = pi[AW-1:0];
    end else if (state == S_PC && op_r != OP_BREAK) begin
      e_we = 1'b1;
      e_wd = neg ? neg9(rdata) : rdata;
    end else if (state == S_PD) begin
      e_we = 1'b1;
      e_wa = b[AW-1:0];
      e_wd = neg ? neg9(ea) : ea;
    end
    i_we = (state == S_SCAN) && d_valid && (op_r == OP_FIND)
           && (LW'(rmag) < LW'(MAX_LEN));
    i_wa = AW'(rmag);
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa] <= e_wd;
    rdata <= emem[e_ra];
    if (i_we) imem[i_wa] <= d_idx[AW-1:0];
    irdata <= imem[AW'(mag9(val_r))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      perm_type <= T_REV;
      perm_length <= 9'd2;
      inv_valid <= 1'b0;
      done <= 1'b0;
      result_value <= '0;
      result_flag <= 1'b0;
      status <= ST_OK;
      sc_issue <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == CFG_TYPE) perm_type <= cfg_data[2:0];
        else perm_length <= cfg_data;
      end
      if (state == S_SCAN) begin
        if (sc_issue) begin
          sc_raddr <= sc_raddr + LW'(1);
          if (sc_raddr == sc_end) sc_issue <= 1'b0;
        end
        d_valid <= sc_issue;
        d_idx <= sc_raddr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= op_in;
            i_r <= pi;
            j_r <= pj;
            k_r <= pk;
            val_r <= elem_value;
            a <= pi;
            b <= pj;
            neg <= 1'b0;
            tx_ph <= 2'd0;
            result_value <= '0;
            result_flag <= 1'b0;
            status <= ST_OK;
            sc_issue <= 1'b1;
            d_valid <= 1'b0;
            sc_start <= '0;
            sc_raddr <= '0;
            sc_end <= len - LW'(1);
            unique case (op_in)
              OP_WRITE: begin
                done <= 1'b1;
                if (pi < len) inv_valid <= 1'b0;
                else status <= ST_RANGE;
              end
              OP_READ: begin
                if (pi < len) state <= S_PA;
                else begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end
              end
              OP_REVERSE: begin
                if (!rev_ok) begin
                  done <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (pi > pj || pj >= len) begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end else begin
                  inv_valid <= 1'b0;
                  neg <= neg_type;
                  if (pi < pj || neg_type) state <= S_PA;
                  else done <= 1'b1;
                end
              end
              OP_TRANS: begin
                if (!trn_ok) begin
                  done <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (pi > pj || pj > pk || pk > len) begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end else begin
                  inv_valid <= 1'b0;
                  state <= S_TX;
                end
              end
              OP_BREAK: begin
                if (!type_ok) begin
                  done <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (pi >= len || pj >= len) begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end else state <= S_PA;
              end
              OP_FIND: begin
                if (inv_valid) state <= S_LK;
                else state <= S_SCAN;
              end
              OP_STRIP: begin
                if (!type_ok) begin
                  done <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (pi >= len) begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end else if (pi + LW'(1) >= len) begin
                  done <= 1'b1;
                  result_value <= 9'(pi);
                end else begin
                  sc_start <= pi;
                  sc_raddr <= pi;
                  state <= S_SCAN;
                end
              end
              OP_SINGLE: begin
                if (!type_ok) begin
                  done <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (pi < LW'(1) || pi + LW'(1) >= len) begin
                  done <= 1'b1;
                  status <= ST_RANGE;
                end else begin
                  sc_start <= pi - LW'(1);
                  sc_raddr <= pi - LW'(1);
                  sc_end <= pi + LW'(1);
                  state <= S_SCAN;
                end
              end
              OP_SORTED: state <= S_SCAN;
              default: begin
                done <= 1'b1;
                status <= ST_ILLEGAL;
              end
            endcase
          end
        end
        S_PA: state <= S_PB;
        S_PB: begin
          ea <= rdata;
          if (op_r == OP_READ) begin
            done <= 1'b1;
            result_value <= rdata;
            state <= S_IDLE;
          end else state <= S_PC;
        end
        S_PC: begin
          if (op_r == OP_BREAK) begin
            done <= 1'b1;
            result_flag <= cmp_res.brk;
            state <= S_IDLE;
          end else state <= S_PD;
        end
        S_PD: begin
          if ((a + LW'(2) < b) || (a + LW'(2) == b && neg)) begin
            a <= a + LW'(1);
            b <= b - LW'(1);
            state <= S_PA;
          end else if (op_r == OP_TRANS) begin
            tx_ph <= tx_ph + 2'd1;
            state <= S_TX;
          end else begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_TX: begin
          if (tx_ph == 2'd3) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else if (tx_cond && tx_x < tx_y) begin
            a <= tx_x;
            b <= tx_y;
            state <= S_PA;
          end else tx_ph <= tx_ph + 2'd1;
        end
        S_SCAN: begin
          if (d_valid) begin
            unique case (op_r)
              OP_FIND: begin
                if (d_idx == sc_end) begin
                  inv_valid <= 1'b1;
                  state <= S_LK;
                end
              end
              OP_STRIP: begin
                if (d_idx == sc_start) prev <= rdata;
                else if (cmp_res.brk) begin
                  done <= 1'b1;
                  result_value <= 9'(d_idx - LW'(1));
                  state <= S_IDLE;
                end else if (d_idx == sc_end) begin
                  done <= 1'b1;
                  result_value <= 9'(d_idx);
                  state <= S_IDLE;
                end else prev <= rdata;
              end
              OP_SINGLE: begin
                if (d_idx == sc_start) prev <= rdata;
                else if (d_idx != sc_end) begin
                  b1 <= cmp_res.brk;
                  prev <= rdata;
                end else begin
                  done <= 1'b1;
                  result_flag <= b1 && cmp_res.brk;
                  state <= S_IDLE;
                end
              end
              default: begin
                // sorted test
                if (d_idx == sc_start) prev <= rdata;
                else if (cmp_res.gt) begin
                  done <= 1'b1;
                  state <= S_IDLE;
                end else if (d_idx == sc_end) begin
                  done <= 1'b1;
                  result_flag <= 1'b1;
                  state <= S_IDLE;
                end else prev <= rdata;
              end
            endcase
          end
        end
        S_LK: begin
          if (LW'(mag9(val_r)) >= LW'(MAX_LEN)) begin
            done <= 1'b1;
            status <= ST_NOTFOUND;
            state <= S_IDLE;
          end else state <= S_LK2;
        end
        S_LK2: begin
          if (LW'(irdata) < len) begin
            a <= LW'(irdata);
            state <= S_LK3;
          end else begin
            done <= 1'b1;
            status <= ST_NOTFOUND;
            state <= S_IDLE;
          end
        end
        S_LK3: begin
          done <= 1'b1;
          if (rdata == val_r) begin
            result_value <= 9'(a);
            result_flag <= 1'b1;
          end else status <= ST_NOTFOUND;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pre_checker.sv
// Port-level checker of the rearrangement engine, bound to the top level.
`default_nettype none
`include "permutation_rearrangement_engine_defines.svh"
module pre_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic signed [8:0] result_value,
  input logic              result_flag,
  input logic [1:0]        status
);
  import pre_pkg::*;

  // an accepted item either finishes at once or keeps the block busy
  `PRE_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `PRE_ASSERT_IMP(a_done_idle, done, !busy)
  `PRE_ASSERT_IMP(a_error_zero, done && status != ST_OK, result_value == 9'sd0 && !result_flag)
  // with no new item taken, a result strobe lasts one cycle
  `PRE_ASSERT_NXT(a_single_strobe, done && !start, !done)

endmodule

bind permutation_rearrangement_engine pre_checker u_pre_checker (.*);
`default_nettype wire
